### hw/rtl/bcl_pkg.sv
package bcl_pkg;

  // default sizes of the list
  localparam int unsigned DEF_CAPACITY  = 16;
  localparam int unsigned DEF_WARD_BITS = 16;
  localparam int unsigned DEF_ID_BITS   = 32;

  // register file
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_PROTECT_ADDR = 2'd0;

  typedef enum logic [2:0] {
    ACT_APPEND     = 3'd0,
    ACT_NEXT       = 3'd1,
    ACT_PREV       = 3'd2,
    ACT_REMOVE_CUR = 3'd3,
    ACT_REMOVE_ID  = 3'd4,
    ACT_CLEAR      = 3'd5,
    ACT_QUERY      = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

endpackage

### hw/rtl/bcl_store.sv
module bcl_store #(
  parameter int unsigned DEPTH = bcl_pkg::DEF_CAPACITY,
  parameter int unsigned WIDTH = bcl_pkg::DEF_WARD_BITS + bcl_pkg::DEF_ID_BITS,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  import bcl_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] fwd_data_q;
  logic             fwd_hit_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q       <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // a read of the entry being written returns the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else begin
      fwd_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rd_q;

endmodule

### hw/rtl/bounded_call_list_with_cursor.sv
// channel   direction  handshake                   payload
// request   in         start_i high, busy_o low    action_i, ward_code_i, device_id_i
// result    out        done_o high for one cycle   status_o, entry_count_o, cursor_valid_o,
//                                                  cursor_position_o, current_ward_o,
//                                                  current_id_o
// config    in/out     psel, penable, pwrite       paddr, pwdata, prdata (pready tied high)
//
// append, next, prev, clear and query: the result comes in the cycle after the
// accepting one, and no new request is taken before it; the list memory is written
// and the cursor entry read in the accepting cycle.
// remove at cursor p: entries after p move down, one entry moved per cycle
// through the single read and write port of the list memory while the gap closes.
// remove by id: the entries are read in order and each id compared with the key
// from the registered read; a hit at position i closes the gap as above, and no
// match leaves the list as it is. The memory reads one entry per cycle.
// reset clears counters and cursor at once; the list memory needs no clearing pass.
// the receiver cannot stall, and busy_o is high from the accepting edge until the
// result cycle ends.
module bounded_call_list_with_cursor #(
  parameter int unsigned CAPACITY  = bcl_pkg::DEF_CAPACITY,
  parameter int unsigned WARD_BITS = bcl_pkg::DEF_WARD_BITS,
  parameter int unsigned ID_BITS   = bcl_pkg::DEF_ID_BITS,
  parameter int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CNT_W     = $clog2(CAPACITY + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [2:0]                   action_i,
  input  logic [WARD_BITS-1:0]         ward_code_i,
  input  logic [ID_BITS-1:0]           device_id_i,
  // result
  output logic                         done_o,
  output bcl_pkg::status_e             status_o,
  output logic [CNT_W-1:0]             entry_count_o,
  output logic                         cursor_valid_o,
  output logic [IDX_W-1:0]             cursor_position_o,
  output logic [WARD_BITS-1:0]         current_ward_o,
  output logic [ID_BITS-1:0]           current_id_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcl_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import bcl_pkg::*;

  localparam int unsigned WIDTH = WARD_BITS + ID_BITS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_FIN    = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  // logical position to physical slot of the ring
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                            input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IDX_W+1)'(CAPACITY)) begin
      s = s - (IDX_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  state_e             state_q, state_d;
  status_e            st_q, st_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   cur_idx_q, cur_idx_d;
  logic               cur_v_q, cur_v_d;
  logic               protect_q;
  logic [ID_BITS-1:0] target_q, target_d;
  logic [IDX_W-1:0]   drop_p_q, drop_p_d;
  logic               drop_q, drop_d;
  logic [CNT_W-1:0]   sh_rd_q, sh_rd_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]   sr_q, sr_d;
  logic               cmp_q, cmp_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [WIDTH-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [WIDTH-1:0]   mem_rdata;
  logic [IDX_W-1:0]   rd_base;
  logic [IDX_W-1:0]   rd_ofs;
  logic               full;
  logic               cfg_wr;

  assign full = (count_q == CNT_W'(CAPACITY));

  // list memory holding ward and id per slot
  bcl_store #(
    .DEPTH (CAPACITY),
    .WIDTH (WIDTH),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    st_d      = st_q;
    head_d    = head_q;
    count_d   = count_q;
    cur_idx_d = cur_idx_q;
    cur_v_d   = cur_v_q;
    target_d  = target_q;
    drop_p_d  = drop_p_q;
    drop_d    = drop_q;
    sh_rd_d   = sh_rd_q;
    pend_d    = 1'b0;
    wr_idx_d  = wr_idx_q;
    sr_d      = sr_q;
    cmp_d     = 1'b0;
    cmp_idx_d = cmp_idx_q;
    mem_we    = 1'b0;
    mem_waddr = phys(head_q, count_q[IDX_W-1:0]);
    mem_wdata = {ward_code_i, device_id_i};
    rd_base   = head_q;
    rd_ofs    = cur_idx_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          st_d    = ST_OK;
          state_d = S_RESP;
          case (action_i)
            ACT_APPEND: begin
              if ((ward_code_i == '0) || (device_id_i == '0)) begin
                st_d = ST_INVALID;
              end else if (full) begin
                if (protect_q) begin
                  st_d = ST_FULL;
                end else begin
                  // evict the oldest, its slot becomes the new tail
                  head_d    = phys(head_q, IDX_W'(1));
                  mem_we    = 1'b1;
                  mem_waddr = head_q;
                  if (cur_v_q) begin
                    cur_idx_d = (cur_idx_q == '0) ? '0 : cur_idx_q - IDX_W'(1);
                  end else begin
                    cur_v_d = (CAPACITY == 1);
                  end
                end
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (count_q == '0) begin
                  cur_v_d   = 1'b1;
                  cur_idx_d = '0;
                end
              end
            end
            ACT_NEXT: begin
              if (!cur_v_q || (count_q == '0)) begin
                st_d = ST_EMPTY;
              end else if ((CNT_W'(cur_idx_q) + CNT_W'(1)) < count_q) begin
                cur_idx_d = cur_idx_q + IDX_W'(1);
              end
            end
            ACT_PREV: begin
              if (!cur_v_q || (count_q == '0)) begin
                st_d = ST_EMPTY;
              end else if (cur_idx_q != '0) begin
                cur_idx_d = cur_idx_q - IDX_W'(1);
              end
            end
            ACT_REMOVE_CUR: begin
              if (!cur_v_q || (count_q == '0) || (CNT_W'(cur_idx_q) >= count_q)) begin
                st_d = ST_EMPTY;
              end else begin
                drop_p_d = cur_idx_q;
                drop_d   = 1'b1;
                sh_rd_d  = CNT_W'(cur_idx_q) + CNT_W'(1);
                state_d  = S_SHIFT;
              end
            end
            ACT_REMOVE_ID: begin
              st_d = ST_EMPTY;
              if (device_id_i != '0) begin
                target_d = device_id_i;
                sr_d     = '0;
                state_d  = S_SEARCH;
              end
            end
            ACT_CLEAR: begin
              count_d   = '0;
              cur_idx_d = '0;
              cur_v_d   = 1'b0;
              head_d    = '0;
            end
            default: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end
            end
          endcase
          rd_base = head_d;
          rd_ofs  = cur_idx_d;
        end
      end
      S_SEARCH: begin
        // one read per cycle, compare on the following cycle
        if (cmp_q && (mem_rdata[ID_BITS-1:0] == target_q)) begin
          drop_p_d = cmp_idx_q;
          drop_d   = 1'b1;
          sh_rd_d  = CNT_W'(cmp_idx_q) + CNT_W'(1);
          st_d     = ST_OK;
          state_d  = S_SHIFT;
        end else if (sr_q < count_q) begin
          rd_ofs    = sr_q[IDX_W-1:0];
          cmp_d     = 1'b1;
          cmp_idx_d = sr_q[IDX_W-1:0];
          sr_d      = sr_q + CNT_W'(1);
        end else if (!cmp_q) begin
          drop_d  = 1'b0;
          state_d = S_FIN;
        end
      end
      S_SHIFT: begin
        // move entry k down to k-1, read of k+1 overlapping the write of k-1
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head_q, wr_idx_q);
          mem_wdata = mem_rdata;
        end
        if (sh_rd_q < count_q) begin
          rd_ofs   = sh_rd_q[IDX_W-1:0];
          pend_d   = 1'b1;
          wr_idx_d = sh_rd_q[IDX_W-1:0] - IDX_W'(1);
          sh_rd_d  = sh_rd_q + CNT_W'(1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // close the count and move the cursor after a removal
        if (drop_q) begin
          count_d = count_q - CNT_W'(1);
          if (cur_v_q) begin
            if (count_q == CNT_W'(1)) begin
              cur_v_d   = 1'b0;
              cur_idx_d = '0;
            end else if (cur_idx_q > drop_p_q) begin
              cur_idx_d = cur_idx_q - IDX_W'(1);
            end else if ((cur_idx_q == drop_p_q) &&
                         (CNT_W'(drop_p_q) == (count_q - CNT_W'(1)))) begin
              cur_idx_d = drop_p_q - IDX_W'(1);
            end
          end
        end
        rd_ofs  = cur_idx_d;
        state_d = S_RESP;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    mem_raddr = phys(rd_base, rd_ofs);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      st_q      <= ST_OK;
      head_q    <= '0;
      count_q   <= '0;
      cur_idx_q <= '0;
      cur_v_q   <= 1'b0;
      drop_q    <= 1'b0;
      pend_q    <= 1'b0;
      cmp_q     <= 1'b0;
      sh_rd_q   <= '0;
      sr_q      <= '0;
    end else begin
      state_q   <= state_d;
      st_q      <= st_d;
      head_q    <= head_d;
      count_q   <= count_d;
      cur_idx_q <= cur_idx_d;
      cur_v_q   <= cur_v_d;
      drop_q    <= drop_d;
      pend_q    <= pend_d;
      cmp_q     <= cmp_d;
      sh_rd_q   <= sh_rd_d;
      sr_q      <= sr_d;
    end
  end

  // working positions and search key
  always_ff @(posedge clk_i) begin
    target_q  <= target_d;
    drop_p_q  <= drop_p_d;
    wr_idx_q  <= wr_idx_d;
    cmp_idx_q <= cmp_idx_d;
  end

  // configuration register
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_PROTECT_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protect_q <= 1'b0;
    end else if (cfg_wr) begin
      protect_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == REG_PROTECT_ADDR) ? {31'b0, protect_q} : 32'b0;
  assign pready = 1'b1;

  // result ports
  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = (state_q == S_RESP);
  assign status_o          = st_q;
  assign entry_count_o     = count_q;
  assign cursor_valid_o    = cur_v_q;
  assign cursor_position_o = cur_v_q ? cur_idx_q : '0;
  assign current_ward_o    = cur_v_q ? mem_rdata[WIDTH-1:ID_BITS] : '0;
  assign current_id_o      = cur_v_q ? mem_rdata[ID_BITS-1:0] : '0;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (CNT_W'(cur_idx_q) < count_q))
    else $error("cursor beyond the last entry");

  a_cursor_iff_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q == (count_q != '0))
    else $error("cursor presence disagrees with entry count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request accepted without going busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

endmodule
